FILE: rtl/jbcu_pkg.sv
`timescale 1ns / 1ps

package jbcu_pkg;

    localparam int NUM_COMPONENTS = 4;
    localparam int COMP_IDX_W     = (NUM_COMPONENTS > 1) ? $clog2(NUM_COMPONENTS) : 1;

    localparam int BLOCK_LEN   = 64;
    localparam int ZRL_RUN     = 16;
    localparam int DC_MAX_SIZE = 11;
    localparam int AC_MAX_SIZE = 10;

    localparam logic [7:0] SYM_EOB = 8'h00;
    localparam logic [7:0] SYM_ZRL = 8'hF0;
    localparam logic [3:0] NIBBLE  = 4'hF;

    localparam int S_DATA_W = 24;
    localparam int S_USER_W = 1;
    localparam int M_DATA_W = 24;
    localparam int M_USER_W = 2;

    localparam logic [1:0] ERR_NONE    = 2'd0;
    localparam logic [1:0] ERR_OVERRUN = 2'd1;
    localparam logic [1:0] ERR_SIZE    = 2'd2;

    localparam logic FUNC_DC = 1'b0;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic decode;
        logic step;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic plan_empty;
        logic last_step;
        logic out_free;
    } sts_t;

    // Sign-extends the JPEG magnitude bits of a given size category.
    function automatic logic [15:0] mag_value(input logic [3:0] size,
                                              input logic [10:0] bits);
        logic [11:0] mask;
        logic [10:0] b;
        logic [10:0] shifted;
        logic [15:0] res;
        mask    = (12'd1 << size) - 12'd1;
        b       = bits & mask[10:0];
        shifted = b >> (size - 4'd1);
        if (size == 4'd0 || size > 4'(DC_MAX_SIZE)) begin
            res = 16'd0;
        end else if (shifted[0]) begin
            res = {5'd0, b};
        end else begin
            res = {5'd0, b} - {5'd0, mask[10:0]};
        end
        return res;
    endfunction

endpackage

FILE: rtl/jpeg_block_coefficient_unpack.sv
`timescale 1ns / 1ps

// Unpacks Huffman-decoded JPEG symbols into the zig-zag coefficients of an
// 8x8 block, one coefficient per output transfer. A DC symbol opens a block
// and yields its coefficient at position 0 from the per-component predictor;
// AC symbols fill positions 1 to 63 with zero runs and coefficients, EOB
// fills the rest of the block with zeros and ZRL emits sixteen zeros. An AC
// symbol with no open block is dropped. Errors close the block and are
// reported on a single transfer with tlast set. The controller takes one
// input symbol at a time: it accepts it, decodes it, then emits one
// coefficient per step while the output register is free (one for a DC
// symbol, run plus one for an AC coefficient, up to 63 for EOB). The output
// register lets the next symbol be accepted while the last coefficient
// still waits for m_tready.
module jpeg_block_coefficient_unpack (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // component[1:0], symbol[9:2], extra_bits[20:10], zero fill[23:21]
    input  logic [jbcu_pkg::S_DATA_W-1:0]   s_tdata,
    // func[0]
    input  logic [jbcu_pkg::S_USER_W-1:0]   s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // position[5:0], coefficient[21:6], zero fill[23:22]
    output logic [jbcu_pkg::M_DATA_W-1:0]   m_tdata,
    // error[1:0]
    output logic [jbcu_pkg::M_USER_W-1:0]   m_tuser,
    output logic                            m_tlast
);
    import jbcu_pkg::*;

    cmd_t        cmd;
    sts_t        sts;
    logic [5:0]  position;
    logic [15:0] coefficient;
    logic [1:0]  error_code;

    jbcu_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    jbcu_dp u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .sts             (sts),
        .in_func         (s_tuser[0]),
        .in_component    (s_tdata[1:0]),
        .in_symbol       (s_tdata[9:2]),
        .in_extra_bits   (s_tdata[20:10]),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .out_position    (position),
        .out_coefficient (coefficient),
        .out_last        (m_tlast),
        .out_error       (error_code)
    );

    assign m_tdata = {2'b00, coefficient, position};
    assign m_tuser = error_code;

endmodule

FILE: rtl/jbcu_ctrl.sv
`timescale 1ns / 1ps

module jbcu_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            s_tvalid,
    output logic            s_tready,
    input  jbcu_pkg::sts_t  sts,
    output jbcu_pkg::cmd_t  cmd
);
    import jbcu_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DECODE,
        ST_EMIT
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign s_tready   = (state_reg == ST_IDLE);
    assign cmd.load   = s_tvalid && (state_reg == ST_IDLE);
    assign cmd.decode = (state_reg == ST_DECODE);
    assign cmd.step   = (state_reg == ST_EMIT) && sts.out_free;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                // An AC symbol outside an open block produces nothing.
                state_next = sts.plan_empty ? ST_IDLE : ST_EMIT;
            end
            ST_EMIT:
            begin
                if (sts.out_free && sts.last_step)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

FILE: rtl/jbcu_dp.sv
`timescale 1ns / 1ps

module jbcu_dp (
    input  logic            clk,
    input  logic            rst_n,
    input  jbcu_pkg::cmd_t  cmd,
    output jbcu_pkg::sts_t  sts,
    input  logic            in_func,
    input  logic [1:0]      in_component,
    input  logic [7:0]      in_symbol,
    input  logic [10:0]     in_extra_bits,
    output logic            m_tvalid,
    input  logic            m_tready,
    output logic [5:0]      out_position,
    output logic [15:0]     out_coefficient,
    output logic            out_last,
    output logic [1:0]      out_error
);
    import jbcu_pkg::*;

    // Latched input item.
    logic        func_reg;
    logic [1:0]  comp_reg;
    logic [7:0]  sym_reg;
    logic [10:0] extra_reg;

    // Block state and the plan for the current item.
    logic [6:0]  pos_reg,  pos_next;
    logic [6:0]  cnt_reg,  cnt_next;
    logic        fin_reg,  fin_next;
    logic        close_reg;
    logic [15:0] fcoef_reg;
    logic [1:0]  ferr_reg;
    logic [15:0] pred_reg [NUM_COMPONENTS];

    logic        mvalid_reg, mvalid_next;
    logic [5:0]  opos_reg;
    logic [15:0] ocoef_reg;
    logic        olast_reg;
    logic [1:0]  oerr_reg;

    // Decode results.
    logic [COMP_IDX_W-1:0] idx;
    logic [15:0] dc_sum;
    logic [3:0]  run;
    logic [3:0]  size;
    logic [6:0]  pos_run;
    logic [6:0]  pos_adv;
    logic [6:0]  plan_cnt;
    logic        plan_fin;
    logic        plan_close;
    logic [15:0] plan_coef;
    logic [1:0]  plan_err;
    logic [6:0]  plan_pos;
    logic        plan_empty;
    logic        pred_we;

    assign run     = sym_reg[7:4] & NIBBLE;
    assign size    = sym_reg[3:0] & NIBBLE;
    assign pos_run = pos_reg + {3'd0, run};
    assign pos_adv = (pos_reg + 7'd1 == 7'(BLOCK_LEN)) ? 7'd0 : pos_reg + 7'd1;

    always_comb
    begin
        if ({1'b0, comp_reg} < 3'(NUM_COMPONENTS))
        begin
            idx = comp_reg[COMP_IDX_W-1:0];
        end
        else
        begin
            idx = '0;
        end
    end

    assign dc_sum = pred_reg[idx] + mag_value(sym_reg[3:0], extra_reg);

    always_comb
    begin
        plan_cnt   = 7'd0;
        plan_fin   = 1'b0;
        plan_close = 1'b1;
        plan_coef  = 16'd0;
        plan_err   = ERR_NONE;
        plan_pos   = pos_reg;
        plan_empty = 1'b0;
        pred_we    = 1'b0;
        if (func_reg == FUNC_DC)
        begin
            plan_pos = 7'd0;
            plan_fin = 1'b1;
            if (sym_reg > 8'(DC_MAX_SIZE))
            begin
                plan_err = ERR_SIZE;
            end
            else
            begin
                plan_coef  = dc_sum;
                plan_close = 1'b0;
                pred_we    = 1'b1;
            end
        end
        else if (pos_reg == 7'd0)
        begin
            plan_empty = 1'b1;
        end
        else if (sym_reg == SYM_EOB)
        begin
            plan_cnt = 7'(BLOCK_LEN) - pos_reg;
        end
        else if (sym_reg == SYM_ZRL)
        begin
            if (pos_reg + 7'(ZRL_RUN) > 7'(BLOCK_LEN))
            begin
                plan_fin = 1'b1;
                plan_err = ERR_OVERRUN;
            end
            else
            begin
                plan_cnt = 7'(ZRL_RUN);
            end
        end
        else if (size == 4'd0 || size > 4'(AC_MAX_SIZE))
        begin
            plan_fin = 1'b1;
            plan_err = ERR_SIZE;
        end
        else if (pos_run > 7'(BLOCK_LEN - 1))
        begin
            plan_fin = 1'b1;
            plan_err = ERR_OVERRUN;
        end
        else
        begin
            plan_cnt   = {3'd0, run};
            plan_fin   = 1'b1;
            plan_close = 1'b0;
            plan_coef  = mag_value(size, extra_reg);
        end
    end

    assign sts.plan_empty = plan_empty;
    assign sts.out_free   = !mvalid_reg || m_tready;
    assign sts.last_step  = (cnt_reg == 7'd1 && !fin_reg) || (cnt_reg == 7'd0);

    always_comb
    begin
        pos_next    = pos_reg;
        cnt_next    = cnt_reg;
        fin_next    = fin_reg;
        mvalid_next = mvalid_reg && !m_tready;
        if (cmd.decode)
        begin
            pos_next = plan_pos;
            cnt_next = plan_cnt;
            fin_next = plan_fin;
        end
        else if (cmd.step)
        begin
            mvalid_next = 1'b1;
            if (cnt_reg != 7'd0)
            begin
                cnt_next = cnt_reg - 7'd1;
                pos_next = pos_adv;
            end
            else
            begin
                fin_next = 1'b0;
                pos_next = close_reg ? 7'd0 : pos_adv;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= 7'd0;
            cnt_reg    <= 7'd0;
            fin_reg    <= 1'b0;
            mvalid_reg <= 1'b0;
            for (int i = 0; i < NUM_COMPONENTS; i++)
            begin
                pred_reg[i] <= 16'd0;
            end
        end
        else
        begin
            pos_reg    <= pos_next;
            cnt_reg    <= cnt_next;
            fin_reg    <= fin_next;
            mvalid_reg <= mvalid_next;
            if (cmd.decode && pred_we)
            begin
                pred_reg[idx] <= dc_sum;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            func_reg  <= in_func;
            comp_reg  <= in_component;
            sym_reg   <= in_symbol;
            extra_reg <= in_extra_bits;
        end
        if (cmd.decode)
        begin
            close_reg <= plan_close;
            fcoef_reg <= plan_coef;
            ferr_reg  <= plan_err;
        end
        if (cmd.step)
        begin
            opos_reg <= pos_reg[5:0];
            if (cnt_reg != 7'd0)
            begin
                ocoef_reg <= 16'd0;
                oerr_reg  <= ERR_NONE;
                olast_reg <= (pos_reg == 7'(BLOCK_LEN - 1));
            end
            else
            begin
                ocoef_reg <= fcoef_reg;
                oerr_reg  <= ferr_reg;
                olast_reg <= (ferr_reg != ERR_NONE) || (pos_reg == 7'(BLOCK_LEN - 1));
            end
        end
    end

    assign m_tvalid        = mvalid_reg;
    assign out_position    = opos_reg;
    assign out_coefficient = ocoef_reg;
    assign out_last        = olast_reg;
    assign out_error       = oerr_reg;

endmodule
